// File: rtl/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg: shared types and constants for the UTF-8 sanitizer
// Word structs for both channels, the replacement sequence and decode limits.
// ----------------------------------------------------------------------------
package utf8s_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_t;

  // U+FFFD encoded as UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [20:0] MAX_SCALAR    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO       = 21'h00D800;
  localparam logic [20:0] SURR_HI       = 21'h00DFFF;
  localparam logic [20:0] MIN_LEN2      = 21'h000080;
  localparam logic [20:0] MIN_LEN3      = 21'h000800;
  localparam logic [20:0] MIN_LEN4      = 21'h010000;
  localparam logic [20:0] C1_HI         = 21'h00009F;
  localparam logic [7:0]  ASCII_DEL     = 8'h7F;
  localparam logic [7:0]  ASCII_LF      = 8'h0A;
  localparam logic [7:0]  ASCII_TAB     = 8'h09;
  localparam logic [7:0]  ASCII_SPACE   = 8'h20;

  // sequence length announced by a lead byte, 0 when it is no lead
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] n;
    n = 3'd0;
    if ((c & 8'hE0) == 8'hC0) n = 3'd2;
    else if ((c & 8'hF0) == 8'hE0) n = 3'd3;
    else if ((c & 8'hF8) == 8'hF0) n = 3'd4;
    return n;
  endfunction

  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = REPL_B0;
      2'd1:    b = REPL_B1;
      default: b = REPL_B2;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/utf8_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_sanitizer: UTF-8 validation with U+FFFD replacement
// Cleans a byte stream: drops controls, copies well-formed scalars and
// replaces malformed sequences with EF BF BD.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_i) takes one raw byte per
//   word plus in_last on the final byte of a text. Output channel
//   (out_valid_o / out_ready_i / out_o) returns cleaned bytes; run_last
//   marks the last output word caused by one input word. An input word may
//   cause no output at all.
//   One word at a time: in_ready_o is high only while the sequencer idles.
//   Per input word the sequencer takes it, judges the window front until a
//   judgment finds it empty or waiting, emits each output byte (a
//   replacement gives three), skips the continuations after a cut-short
//   sequence and then leaves the skip, and flushes the held byte, if any.
//   Results go through a held byte and an output register, so the final
//   byte is known to carry run_last before it is shown.
//   Reset empties the window and the output register. A stalled receiver
//   freezes the sequencer at its next output byte; nothing is dropped.
// ----------------------------------------------------------------------------
module utf8_sanitizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  utf8s_pkg::in_t    in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output utf8s_pkg::out_t   out_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_EMIT   = 3'd2;
  localparam logic [2:0] S_SKIP   = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  logic [2:0] state_q, state_d;

  // byte window, front at index 0
  logic [7:0] held_q [4];
  logic [2:0] count_q;
  logic       last_q;

  // current emit job
  logic [2:0] emit_n_q, emit_n_d;
  logic       repl_q, repl_d;
  logic [2:0] drop_q, drop_d;
  logic       skip_q, skip_d;
  logic [1:0] idx_q, idx_d;

  // held-back byte: it gets run_last once we know nothing follows
  logic [7:0] pend_q, pend_d;
  logic       pend_v_q, pend_v_d;

  utf8s_pkg::out_t out_q, out_d;
  logic            out_v_q, out_v_d;

  logic in_acc;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  logic slot_free;
  assign slot_free = !out_v_q || out_ready_i;

  // ---------------------------------------------------------------------
  // Judgment of the window front
  // ---------------------------------------------------------------------
  logic [7:0]  c;
  logic [2:0]  len;
  logic        cont_bad;
  logic [20:0] v;
  logic [2:0]  d_n;
  logic        d_repl;
  logic [2:0]  d_drop;
  logic        d_skip;
  logic        d_wait;

  always_comb begin
    c        = held_q[0];
    len      = utf8s_pkg::lead_len(c);
    cont_bad = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (3'(k) < len && held_q[k][7:6] != 2'b10) cont_bad = 1'b1;
    end
    case (len)
      3'd2:    v = {10'd0, c[4:0], held_q[1][5:0]};
      3'd3:    v = {5'd0, c[3:0], held_q[1][5:0], held_q[2][5:0]};
      default: v = {c[2:0], held_q[1][5:0], held_q[2][5:0], held_q[3][5:0]};
    endcase

    d_n    = 3'd0;
    d_repl = 1'b0;
    d_drop = 3'd1;
    d_skip = 1'b0;
    d_wait = 1'b0;
    if (count_q == 3'd0) begin
      d_wait = 1'b1;
    end else if (!c[7]) begin
      if (c == utf8s_pkg::ASCII_LF || c == utf8s_pkg::ASCII_TAB ||
          (c >= utf8s_pkg::ASCII_SPACE && c != utf8s_pkg::ASCII_DEL)) begin
        d_n = 3'd1;
      end
    end else if (len == 3'd0) begin
      d_n    = 3'd3;
      d_repl = 1'b1;
    end else if (count_q < len) begin
      if (!last_q) begin
        d_wait = 1'b1;
      end else begin
        // cut short by end of text: one replacement, skip its continuations
        d_n    = 3'd3;
        d_repl = 1'b1;
        d_skip = 1'b1;
      end
    end else if (cont_bad) begin
      // only the lead goes; the rest is judged again
      d_n    = 3'd3;
      d_repl = 1'b1;
    end else begin
      d_drop = len;
      if ((len == 3'd2 && v < utf8s_pkg::MIN_LEN2) ||
          (len == 3'd3 && v < utf8s_pkg::MIN_LEN3) ||
          (len == 3'd4 && v < utf8s_pkg::MIN_LEN4) ||
          (v >= utf8s_pkg::SURR_LO && v <= utf8s_pkg::SURR_HI) ||
          v > utf8s_pkg::MAX_SCALAR) begin
        d_n    = 3'd3;
        d_repl = 1'b1;
      end else if (v > utf8s_pkg::C1_HI) begin
        d_n = len;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic       sh_en;
  logic [2:0] sh_k;
  logic       gen_en;
  logic [7:0] gen_byte;
  logic       push_en;
  logic [7:0] push_byte;
  logic       push_last;

  assign gen_byte = repl_q ? utf8s_pkg::repl_byte(idx_q) : held_q[idx_q];

  always_comb begin
    state_d   = state_q;
    emit_n_d  = emit_n_q;
    repl_d    = repl_q;
    drop_d    = drop_q;
    skip_d    = skip_q;
    idx_d     = idx_q;
    sh_en     = 1'b0;
    sh_k      = drop_q;
    gen_en    = 1'b0;
    push_en   = 1'b0;
    push_byte = pend_q;
    push_last = 1'b0;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (d_wait) begin
          state_d = S_FLUSH;
        end else if (d_n == 3'd0) begin
          sh_en = 1'b1;
          sh_k  = d_drop;
        end else begin
          emit_n_d = d_n;
          repl_d   = d_repl;
          drop_d   = d_drop;
          skip_d   = d_skip;
          idx_d    = 2'd0;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!pend_v_q || slot_free) begin
          gen_en   = 1'b1;
          push_en  = pend_v_q;
          pend_d   = gen_byte;
          pend_v_d = 1'b1;
          if ({1'b0, idx_q} == emit_n_q - 3'd1) begin
            sh_en   = 1'b1;
            state_d = skip_q ? S_SKIP : S_DECIDE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      S_SKIP: begin
        if (count_q != 3'd0 && held_q[0][7:6] == 2'b10) begin
          sh_en = 1'b1;
          sh_k  = 3'd1;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          push_en   = 1'b1;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_d   = out_q;
    out_v_d = out_v_q;
    if (push_en) begin
      out_d.out_byte = push_byte;
      out_d.run_last = push_last;
      out_v_d        = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  // window shifter: drop sh_k bytes from the front
  logic [7:0] shifted [4];
  logic [2:0] src;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      src        = 3'(i) + sh_k;
      shifted[i] = (src < 3'd4) ? held_q[src[1:0]] : held_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= 3'd0;
      last_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      emit_n_q <= 3'd0;
      repl_q   <= 1'b0;
      drop_q   <= 3'd0;
      skip_q   <= 1'b0;
      idx_q    <= 2'd0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      emit_n_q <= emit_n_d;
      repl_q   <= repl_d;
      drop_q   <= drop_d;
      skip_q   <= skip_d;
      idx_q    <= idx_d;
      if (in_acc) begin
        count_q <= count_q + 3'd1;
        last_q  <= in_i.in_last;
      end else if (sh_en) begin
        count_q <= count_q - sh_k;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (in_acc) begin
      held_q[count_q[1:0]] <= in_i.in_byte;
    end else if (sh_en) begin
      for (int i = 0; i < 4; i++) held_q[i] <= shifted[i];
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_window_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> count_q <= 3'd3)
    else $error("window overfull while taking a word");

  a_pend_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("held output byte left over after a step");

  a_text_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && last_q) |-> count_q == 3'd0)
    else $error("window not empty after end of text");

  a_gen_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_en && pend_v_q) |-> slot_free)
    else $error("output byte generated into a full output register");

endmodule
